// ===== rtl/swst_pkg.sv =====
// ----------------------------------------------------------------------------
// swst_pkg
// Shared types, widths and constants of the swerve steering angle block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swst_pkg;

   localparam int WHEEL_COUNT      = 4;
   localparam int WHEEL_IDX_W      = 2;
   localparam int ANGLE_BITS_DEF   = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam int STICK_W  = 11;
   localparam int SWITCH_W = 2;

   // left switch positions, anything but middle halts the drive
   localparam logic [SWITCH_W-1:0] SWITCH_UP     = 2'd0;
   localparam logic [SWITCH_W-1:0] SWITCH_MIDDLE = 2'd1;
   localparam logic [SWITCH_W-1:0] SWITCH_DOWN   = 2'd2;

   // wheel order of the result
   localparam logic [WHEEL_IDX_W-1:0] WHEEL_FL = 2'd0;
   localparam logic [WHEEL_IDX_W-1:0] WHEEL_FR = 2'd1;
   localparam logic [WHEEL_IDX_W-1:0] WHEEL_BL = 2'd2;
   localparam logic [WHEEL_IDX_W-1:0] WHEEL_BR = 2'd3;

   // stick scaled by 2^15, turn by cos(pi/4) in Q15
   localparam int STICK_SHIFT = 15;
   localparam int COS45_Q15   = 23170;

   // wheel vector, cordic datapath and turn accumulator widths
   localparam int VEC_W  = 27;
   localparam int XY_W   = 30;
   localparam int Z_W    = 33;
   localparam int MAG_W  = 32;
   localparam int PROD_W = 63;

   localparam int TAB_LEN   = 24;
   localparam int TAB_IDX_W = 5;

   // arctangent of 2^-i in binary turns, 2^32 per turn
   localparam logic [29:0] ATAN_TURNS [TAB_LEN] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
      30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
      30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
      30'd166886,    30'd83443,     30'd41722,     30'd20861,
      30'd10430,     30'd5215,      30'd2608,      30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81
   };

   localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(1) <<< 30;

   // pi in Q29
   localparam logic [30:0] PI_Q29 = 31'd1686629713;

endpackage

`default_nettype wire

// ===== rtl/swst_cordic.sv =====
// ----------------------------------------------------------------------------
// swst_cordic
// Iterative vectoring cordic: atan2 of one vector, one micro-rotation per
// cycle, then a turn-to-radian scale through one multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swst_cordic
   import swst_pkg::*;
#(
   parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [VEC_W-1:0]      vec_x,
   input  logic signed [VEC_W-1:0]      vec_y,
   output logic                         done,
   output logic signed [ANGLE_BITS-1:0] angle
);

   localparam int STEPS = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
   localparam logic [TAB_IDX_W-1:0] LAST_STEP = TAB_IDX_W'(STEPS - 1);
   localparam int FRAC  = ANGLE_BITS - 3;
   localparam int SHIFT = 60 - FRAC;

   typedef enum logic [3:0] {
      C_IDLE = 4'b0001,
      C_ITER = 4'b0010,
      C_MUL  = 4'b0100,
      C_RND  = 4'b1000
   } cordic_state_type;

   cordic_state_type                state_ff, state_in;
   logic [TAB_IDX_W-1:0]            cnt_ff, cnt_in;
   logic signed [XY_W-1:0]          x_ff, x_in;
   logic signed [XY_W-1:0]          y_ff, y_in;
   logic signed [Z_W-1:0]           z_ff, z_in;
   logic [PROD_W-1:0]               prod_ff, prod_in;
   logic                            neg_ff, neg_in;
   logic                            done_ff, done_in;
   logic signed [ANGLE_BITS-1:0]    angle_ff, angle_in;

   logic signed [XY_W-1:0]          xe, ye, xs, ys;
   logic signed [Z_W-1:0]           atan_z, z_neg;
   logic [MAG_W-1:0]                mag;
   logic [63:0]                     rnd;
   logic [63:0]                     rad;
   logic [ANGLE_BITS-1:0]           rad_cut;

   always_comb begin
      xe      = XY_W'(vec_x);
      ye      = XY_W'(vec_y);
      xs      = x_ff >>> cnt_ff;
      ys      = y_ff >>> cnt_ff;
      atan_z  = $signed(Z_W'(ATAN_TURNS[cnt_ff]));
      z_neg   = -z_ff;
      mag     = z_ff[Z_W-1] ? z_neg[MAG_W-1:0] : z_ff[MAG_W-1:0];
      rnd     = {1'b0, prod_ff} + (64'd1 << (SHIFT - 1));
      rad     = rnd >> SHIFT;
      rad_cut = rad[ANGLE_BITS-1:0];

      state_in = state_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      angle_in = angle_ff;
      done_in  = 1'b0;

      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               cnt_in = '0;
               if (vec_x == '0 && vec_y == '0) begin
                  // zero vector gives angle zero
                  z_in     = '0;
                  state_in = C_MUL;
               end else begin
                  if (vec_x < 0) begin
                     // left half plane: turn a quarter first
                     if (vec_y >= 0) begin
                        x_in = ye;
                        y_in = -xe;
                        z_in = QUARTER_TURN;
                     end else begin
                        x_in = -ye;
                        y_in = xe;
                        z_in = -QUARTER_TURN;
                     end
                  end else begin
                     x_in = xe;
                     y_in = ye;
                     z_in = '0;
                  end
                  state_in = C_ITER;
               end
            end
         end
         C_ITER: begin
            if (!y_ff[XY_W-1]) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_z;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_z;
            end
            if (cnt_ff == LAST_STEP) begin
               state_in = C_MUL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         C_MUL: begin
            prod_in  = PROD_W'(mag) * PROD_W'(PI_Q29);
            neg_in   = z_ff[Z_W-1];
            state_in = C_RND;
         end
         C_RND: begin
            angle_in = neg_ff ? -$signed(rad_cut) : $signed(rad_cut);
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      angle_ff <= angle_in;
   end

   assign done  = done_ff;
   assign angle = angle_ff;

endmodule

`default_nettype wire

// ===== rtl/swerve_steer_angle_deltas.sv =====
// ----------------------------------------------------------------------------
// swerve_steer_angle_deltas
// Steering angle turns of a four wheel swerve drive from one stick command,
// one shared cordic walked over the wheels in turn.
// ----------------------------------------------------------------------------
//  channel | ports                                             | moves
//  --------+---------------------------------------------------+-----------------
//  req     | req_valid req_ready req_stick_* req_left_switch   | stick command in
//  rsp     | rsp_valid rsp_ready rsp_delta_* rsp_killed        | four turns out
//
//  a command runs the cordic over the four wheels in turn, one
//  micro-rotation per cycle per wheel; a wheel with a zero vector skips
//  the micro-rotations, and a killed command does not run the cordic.
//  req_ready is high only while the sequencer is idle; the result sits in an
//  output register so a new command can start while it waits for rsp_ready.
//  reset clears the stored wheel angles and the kill flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swerve_steer_angle_deltas
   import swst_pkg::*;
#(
   parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [STICK_W-1:0]    req_stick_x,
   input  logic signed [STICK_W-1:0]    req_stick_y,
   input  logic signed [STICK_W-1:0]    req_stick_turn,
   input  logic [SWITCH_W-1:0]          req_left_switch,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [ANGLE_BITS-1:0] rsp_delta_front_left,
   output logic signed [ANGLE_BITS-1:0] rsp_delta_front_right,
   output logic signed [ANGLE_BITS-1:0] rsp_delta_back_left,
   output logic signed [ANGLE_BITS-1:0] rsp_delta_back_right,
   output logic                         rsp_killed
);

   localparam int FRAC = ANGLE_BITS - 3;
   localparam logic [63:0] PI_Q_FULL =
      (64'(PI_Q29) + (64'd1 << (28 - FRAC))) >> (29 - FRAC);
   localparam logic signed [ANGLE_BITS:0] PI_Q =
      $signed({1'b0, PI_Q_FULL[ANGLE_BITS-1:0]});

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LOAD = 4'b0010,
      S_WAIT = 4'b0100,
      S_DONE = 4'b1000
   } seq_state_type;

   seq_state_type                state_ff, state_in;
   logic [WHEEL_IDX_W-1:0]       wheel_ff, wheel_in;
   logic                         halted_ff, halted_in;
   logic signed [VEC_W-1:0]      x_ff, x_in;
   logic signed [VEC_W-1:0]      y_ff, y_in;
   logic signed [VEC_W-1:0]      t_ff, t_in;
   logic signed [ANGLE_BITS-1:0] last_ff  [WHEEL_COUNT];
   logic signed [ANGLE_BITS-1:0] last_in  [WHEEL_COUNT];
   logic signed [ANGLE_BITS-1:0] delta_ff [WHEEL_COUNT];
   logic signed [ANGLE_BITS-1:0] delta_in [WHEEL_COUNT];

   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [ANGLE_BITS-1:0] rsp_fl_ff, rsp_fl_in;
   logic signed [ANGLE_BITS-1:0] rsp_fr_ff, rsp_fr_in;
   logic signed [ANGLE_BITS-1:0] rsp_bl_ff, rsp_bl_in;
   logic signed [ANGLE_BITS-1:0] rsp_br_ff, rsp_br_in;
   logic                         rsp_killed_ff, rsp_killed_in;

   logic                         req_xfer;
   logic                         cordic_start;
   logic                         cordic_done;
   logic signed [ANGLE_BITS-1:0] cordic_angle;
   logic signed [VEC_W-1:0]      vec_x, vec_y;
   logic signed [ANGLE_BITS:0]   diff;
   logic signed [ANGLE_BITS:0]   diff_clip;

   swst_cordic #(
      .ANGLE_BITS  (ANGLE_BITS),
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock(clock),
      .reset(reset),
      .start(cordic_start),
      .vec_x(vec_x),
      .vec_y(vec_y),
      .done (cordic_done),
      .angle(cordic_angle)
   );

   assign req_ready    = (state_ff == S_IDLE);
   assign req_xfer     = req_valid & req_ready;
   assign cordic_start = (state_ff == S_LOAD);

   // wheel direction vector with the signs of the current wheel
   always_comb begin
      unique case (wheel_ff)
         WHEEL_FL: begin
            vec_y = y_ff - t_ff;
            vec_x = x_ff - t_ff;
         end
         WHEEL_FR: begin
            vec_y = y_ff - t_ff;
            vec_x = x_ff + t_ff;
         end
         WHEEL_BL: begin
            vec_y = y_ff + t_ff;
            vec_x = x_ff + t_ff;
         end
         WHEEL_BR: begin
            vec_y = y_ff + t_ff;
            vec_x = x_ff - t_ff;
         end
         default: begin
            vec_y = '0;
            vec_x = '0;
         end
      endcase
   end

   always_comb begin
      diff = (ANGLE_BITS + 1)'(cordic_angle) - (ANGLE_BITS + 1)'(last_ff[wheel_ff]);
      if (diff > PI_Q) begin
         diff_clip = PI_Q;
      end else if (diff < -PI_Q) begin
         diff_clip = -PI_Q;
      end else begin
         diff_clip = diff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      wheel_in      = wheel_ff;
      halted_in     = halted_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      t_in          = t_ff;
      last_in       = last_ff;
      delta_in      = delta_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_fl_in     = rsp_fl_ff;
      rsp_fr_in     = rsp_fr_ff;
      rsp_bl_in     = rsp_bl_ff;
      rsp_br_in     = rsp_br_ff;
      rsp_killed_in = rsp_killed_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               x_in     = VEC_W'(req_stick_x) <<< STICK_SHIFT;
               y_in     = VEC_W'(req_stick_y) <<< STICK_SHIFT;
               t_in     = VEC_W'(req_stick_turn) * VEC_W'(COS45_Q15);
               wheel_in = WHEEL_FL;
               // sticky kill on up, down or the unused code
               if (req_left_switch != SWITCH_MIDDLE || halted_ff) begin
                  halted_in = 1'b1;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (cordic_done) begin
               delta_in[wheel_ff] = diff_clip[ANGLE_BITS-1:0];
               last_in[wheel_ff]  = cordic_angle;
               if (wheel_ff == WHEEL_BR) begin
                  state_in = S_DONE;
               end else begin
                  wheel_in = wheel_ff + 1'b1;
                  state_in = S_LOAD;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_killed_in = halted_ff;
               if (halted_ff) begin
                  rsp_fl_in = '0;
                  rsp_fr_in = '0;
                  rsp_bl_in = '0;
                  rsp_br_in = '0;
               end else begin
                  rsp_fl_in = delta_ff[WHEEL_FL];
                  rsp_fr_in = delta_ff[WHEEL_FR];
                  rsp_bl_in = delta_ff[WHEEL_BL];
                  rsp_br_in = delta_ff[WHEEL_BR];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wheel_ff     <= WHEEL_FL;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WHEEL_COUNT; i++) begin
            last_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         wheel_ff     <= wheel_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      t_ff          <= t_in;
      delta_ff      <= delta_in;
      rsp_fl_ff     <= rsp_fl_in;
      rsp_fr_ff     <= rsp_fr_in;
      rsp_bl_ff     <= rsp_bl_in;
      rsp_br_ff     <= rsp_br_in;
      rsp_killed_ff <= rsp_killed_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_delta_front_left  = rsp_fl_ff;
   assign rsp_delta_front_right = rsp_fr_ff;
   assign rsp_delta_back_left   = rsp_bl_ff;
   assign rsp_delta_back_right  = rsp_br_ff;
   assign rsp_killed            = rsp_killed_ff;

endmodule

`default_nettype wire
